// File: src/drq_pkg.sv
`timescale 1ns / 1ps

package drq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_RECORD_BITS = 64;

    // Field widths of the request and response beats.
    localparam int REC_FIELD_W = 64;
    localparam int CNT_FIELD_W = 7;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_DUP   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    typedef struct packed {
        logic                   req_type;
        logic [REC_FIELD_W-1:0] new_record;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [REC_FIELD_W-1:0] head_record;
        logic                   head_valid;
        logic [CNT_FIELD_W-1:0] entry_count;
    } t_out_item;

endpackage

// File: src/drq_store.sv
`timescale 1ns / 1ps

module drq_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between reads, so a waiting response keeps its head.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/drq_ctrl.sv
`timescale 1ns / 1ps

module drq_ctrl #(
    parameter int QUEUE_DEPTH = drq_pkg::DEF_QUEUE_DEPTH,
    parameter int RECORD_BITS = drq_pkg::DEF_RECORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  drq_pkg::t_in_item              i_in_data,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output drq_pkg::t_out_item             o_res,
    output logic                           o_mem_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_mem_wr_addr,
    output logic [RECORD_BITS-1:0]         o_mem_wr_data,
    output logic                           o_mem_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_mem_rd_addr,
    input  logic [RECORD_BITS-1:0]         i_mem_rd_data
);

    import drq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_HEAD,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [RECORD_BITS-1:0] r_rec, n_rec;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_scan_ptr, n_scan_ptr;
    logic [CNT_W-1:0] r_issue_cnt, n_issue_cnt;
    logic             r_cmp_pending, n_cmp_pending;
    logic [1:0]       r_status, n_status;

    logic scan_rd;
    logic hit;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // The scan issues one read per cycle and compares the returned data in the cycle after each read.
    assign scan_rd = (r_state == S_SCAN) && (r_issue_cnt < r_count);
    assign hit     = r_cmp_pending && (i_mem_rd_data == r_rec);

    always_comb begin
        n_state       = r_state;
        n_rec         = r_rec;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_count       = r_count;
        n_scan_ptr    = r_scan_ptr;
        n_issue_cnt   = r_issue_cnt;
        n_cmp_pending = r_cmp_pending;
        n_status      = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rec = i_in_data.new_record[RECORD_BITS-1:0];
                    if (i_in_data.req_type == REQ_ADD) begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_HEAD;
                        end else begin
                            n_scan_ptr    = r_rd_ptr;
                            n_issue_cnt   = '0;
                            n_cmp_pending = 1'b0;
                            n_state       = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                        end else begin
                            n_status = STATUS_GOOD;
                            n_rd_ptr = next_slot(r_rd_ptr);
                            n_count  = r_count - 1'b1;
                        end
                        n_state = S_HEAD;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_pending = scan_rd;
                if (scan_rd) begin
                    n_scan_ptr  = next_slot(r_scan_ptr);
                    n_issue_cnt = r_issue_cnt + 1'b1;
                end
                if (hit) begin
                    n_status = STATUS_DUP;
                    n_state  = S_HEAD;
                end else if (!scan_rd && !r_cmp_pending) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_status = STATUS_GOOD;
                n_wr_ptr = next_slot(r_wr_ptr);
                n_count  = r_count + 1'b1;
                n_state  = S_HEAD;
            end
            S_HEAD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
            r_cmp_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rd_ptr      <= n_rd_ptr;
            r_wr_ptr      <= n_wr_ptr;
            r_count       <= n_count;
            r_cmp_pending <= n_cmp_pending;
        end
        r_rec       <= n_rec;
        r_scan_ptr  <= n_scan_ptr;
        r_issue_cnt <= n_issue_cnt;
        r_status    <= n_status;
    end

    assign o_in_stall = (r_state != S_IDLE);

    assign o_mem_wr_en   = (r_state == S_WRITE);
    assign o_mem_wr_addr = r_wr_ptr;
    assign o_mem_wr_data = r_rec;
    assign o_mem_rd_en   = scan_rd || (r_state == S_HEAD);
    assign o_mem_rd_addr = (r_state == S_HEAD) ? r_rd_ptr : r_scan_ptr;

    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status      = r_status;
        o_res.head_valid  = (r_count != '0);
        o_res.head_record = (r_count != '0) ? REC_FIELD_W'(i_mem_rd_data) : '0;
        o_res.entry_count = CNT_FIELD_W'(r_count);
    end

endmodule

// File: src/dedup_ring_queue_core.sv
`timescale 1ns / 1ps

// Ring-buffer queue of records that refuses duplicates. Each request beat
// returns one response beat with a status, the head record and the count.
// The records live in one single-port-read memory, and an add reads the
// queued entries one per cycle to look for a match. An add that is
// appended passes through the scan, the write and the head read before
// its response is presented; a duplicate found early ends the scan.
// A remove, or an add refused as full, goes straight to the head read.
// One request is handled at a time; the response sits in an output
// register so a new request can be taken while it waits.
// The memory needs no clearing after reset: the scan reads only occupied
// entries, and the head read of an empty queue is masked to zero.

module dedup_ring_queue_core #(
    parameter int QUEUE_DEPTH = drq_pkg::DEF_QUEUE_DEPTH,
    parameter int RECORD_BITS = drq_pkg::DEF_RECORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  drq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output drq_pkg::t_out_item o_out_data
);

    import drq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic                   res_valid;
    logic                   res_take;
    t_out_item              res;
    logic                   mem_wr_en;
    logic [PTR_W-1:0]       mem_wr_addr;
    logic [RECORD_BITS-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [PTR_W-1:0]       mem_rd_addr;
    logic [RECORD_BITS-1:0] mem_rd_data;

    logic      r_out_valid;
    t_out_item r_out_data;

    drq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .RECORD_BITS (RECORD_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    drq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RECORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // The output register is free when empty or when its beat leaves now.
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/drq_checker.sv
`timescale 1ns / 1ps

module drq_checker #(
    parameter int QUEUE_DEPTH = drq_pkg::DEF_QUEUE_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input drq_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input drq_pkg::t_out_item o_out_data
);

    import drq_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("request beat changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("response beat changed while stalled");

    a_head_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.head_valid == (o_out_data.entry_count != '0))
                        && (o_out_data.head_valid || o_out_data.head_record == '0))
        else $error("head flag or head record disagrees with the count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_FULL
            |-> o_out_data.entry_count == CNT_FIELD_W'(QUEUE_DEPTH))
        else $error("full status with a queue that is not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_EMPTY
            |-> o_out_data.entry_count == '0)
        else $error("remove-on-empty status with records queued");

endmodule

bind dedup_ring_queue_core drq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_drq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: verif/drq_checker.sv
`timescale 1ns / 1ps

module drq_scoreboard #(
    parameter int QUEUE_DEPTH = drq_pkg::DEF_QUEUE_DEPTH,
    parameter int RECORD_BITS = drq_pkg::DEF_RECORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  drq_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  drq_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    import drq_pkg::*;

    localparam logic [REC_FIELD_W-1:0] REC_MASK =
        {REC_FIELD_W{1'b1}} >> (REC_FIELD_W - RECORD_BITS);

    // Shadow copy of the ring buffer.
    logic [REC_FIELD_W-1:0] shadow_records [QUEUE_DEPTH];
    int unsigned            shadow_rd;
    int unsigned            shadow_wr;
    int unsigned            shadow_fill;

    t_out_item expected_responses[$];
    int        fail_count = 0;
    int        response_index = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_responses.size();

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH response %0d: %s", $realtime, response_index, msg);
        fail_count++;
    endtask

    function automatic int unsigned next_slot(input int unsigned slot);
        return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
    endfunction

    // Applies one request to the shadow queue and returns the response it must produce.
    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item              rsp;
        logic [REC_FIELD_W-1:0] rec;
        int unsigned            slot;
        int unsigned            k;
        bit                     found;
        rec        = req.new_record & REC_MASK;
        rsp.status = STATUS_GOOD;
        found      = 1'b0;
        if (req.req_type == REQ_ADD) begin
            if (shadow_fill >= QUEUE_DEPTH) begin
                rsp.status = STATUS_FULL;
            end else begin
                // Only the occupied span from the head onward is searched.
                slot = shadow_rd;
                for (k = 0; k < shadow_fill; k++) begin
                    if (shadow_records[slot] == rec)
                        found = 1'b1;
                    slot = next_slot(slot);
                end
                if (found) begin
                    rsp.status = STATUS_DUP;
                end else begin
                    shadow_records[shadow_wr] = rec;
                    shadow_wr = next_slot(shadow_wr);
                    shadow_fill++;
                end
            end
        end else begin
            if (shadow_fill == 0) begin
                rsp.status = STATUS_EMPTY;
            end else begin
                shadow_rd = next_slot(shadow_rd);
                shadow_fill--;
            end
        end
        rsp.head_valid  = (shadow_fill != 0);
        rsp.head_record = (shadow_fill != 0) ? (shadow_records[shadow_rd] & REC_MASK) : '0;
        rsp.entry_count = CNT_FIELD_W'(shadow_fill);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_rsp;
        if (!i_rst_n) begin
            shadow_rd   = 0;
            shadow_wr   = 0;
            shadow_fill = 0;
            expected_responses.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_responses.size() == 0) begin
                    report_mismatch("response beat with nothing outstanding");
                end else begin
                    exp_rsp = expected_responses.pop_front();
                    if (i_out_data.status !== exp_rsp.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                            i_out_data.status, exp_rsp.status));
                    if (i_out_data.head_record !== exp_rsp.head_record)
                        report_mismatch($sformatf("head_record got %h expected %h",
                            i_out_data.head_record, exp_rsp.head_record));
                    if (i_out_data.head_valid !== exp_rsp.head_valid)
                        report_mismatch($sformatf("head_valid got %0b expected %0b",
                            i_out_data.head_valid, exp_rsp.head_valid));
                    if (i_out_data.entry_count !== exp_rsp.entry_count)
                        report_mismatch($sformatf("entry_count got %0d expected %0d",
                            i_out_data.entry_count, exp_rsp.entry_count));
                end
                response_index++;
            end
            if (i_in_valid && !i_in_stall)
                expected_responses.push_back(apply_request(i_in_data));
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import drq_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Recently added records, reused to provoke duplicate refusals.
    logic [REC_FIELD_W-1:0] recent_records[$];

    always #5 clk = ~clk;

    dedup_ring_queue_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    drq_scoreboard u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Holds valid until the beat is taken, then idles at random before returning.
    task automatic send_request(input logic req, input logic [REC_FIELD_W-1:0] rec);
        t_in_item item;
        item.req_type   = req;
        item.new_record = rec;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (req == REQ_ADD) begin
            recent_records.push_back(rec);
            if (recent_records.size() > 16)
                void'(recent_records.pop_front());
        end
    endtask

    function automatic logic [REC_FIELD_W-1:0] pick_record();
        if (recent_records.size() != 0 && $urandom_range(0, 99) < 8)
            return recent_records[$urandom_range(0, recent_records.size() - 1)];
        if ($urandom_range(0, 7) == 0)
            return REC_FIELD_W'($urandom_range(0, 3));
        return {$urandom, $urandom};
    endfunction

    // One pass that fills the queue past full and then drains it past empty.
    task automatic fill_and_drain();
        repeat (80) begin
            if ($urandom_range(0, 99) < 97)
                send_request(REQ_ADD, pick_record());
            else
                send_request(REQ_REMOVE, {$urandom, $urandom});
        end
        repeat (75) begin
            if ($urandom_range(0, 99) < 95)
                send_request(REQ_REMOVE, {$urandom, $urandom});
            else
                send_request(REQ_ADD, pick_record());
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 32;
        recv_stall_pct = 88;

        send_request(REQ_REMOVE, 64'h0);
        send_request(REQ_ADD, 64'h0);
        send_request(REQ_ADD, {REC_FIELD_W{1'b1}});
        send_request(REQ_ADD, 64'h0);
        send_request(REQ_ADD, {REC_FIELD_W{1'b1}});
        send_request(REQ_ADD, 64'h8000_0000_0000_0001);
        send_request(REQ_ADD, 64'h5555_5555_5555_5555);
        send_request(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_ADD, 64'h5555_5555_5555_5555);
        send_request(REQ_REMOVE, 64'hFFFF_0000_FFFF_0000);
        send_request(REQ_REMOVE, 64'h0);
        // Both were dropped from the head, so they are no longer duplicates.
        send_request(REQ_ADD, 64'h0);
        send_request(REQ_ADD, {REC_FIELD_W{1'b1}});
        repeat (5)
            send_request(REQ_REMOVE, 64'h0);
        send_request(REQ_REMOVE, {REC_FIELD_W{1'b1}});
        send_request(REQ_ADD, 64'h1);
        send_request(REQ_REMOVE, 64'h0);
        fill_and_drain();

        send_idle_pct  = 88;
        recv_stall_pct = 32;
        fill_and_drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_and_drain();

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: dedup_ring_queue_core.f
src/drq_pkg.sv
src/drq_store.sv
src/drq_ctrl.sv
src/dedup_ring_queue_core.sv
src/drq_checker.sv
verif/drq_checker.sv
verif/tb_top.sv
